/* sv/ast_pkg.sv */
// Shared types, constants and the base decoder for the alignment site statistics block.
package ast_pkg;

    localparam int CNT_W   = 17;
    localparam int TALLY_W = 9;
    localparam int POS_W   = 16;
    localparam int CODE_W  = 3;

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [POS_W-1:0]   POS_MAX   = '1;

    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] CHAR_U      = 8'h55;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [CODE_W-1:0] {
        BASE_MISSING = 3'd0,
        BASE_A       = 3'd1,
        BASE_C       = 3'd2,
        BASE_G       = 3'd3,
        BASE_T       = 3'd4
    } base_code_t;

    typedef struct packed {
        logic [CNT_W-1:0] missing;
        logic [CNT_W-1:0] valid;
    } site_count_t;

    function automatic base_code_t base_code(input logic [7:0] ch);
        logic [7:0]  up;
        base_code_t  code;
        up = ch;
        if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z)
        begin
            up = ch - CASE_OFFSET;
        end
        unique case (up)
            CHAR_A:         code = BASE_A;
            CHAR_C:         code = BASE_C;
            CHAR_G:         code = BASE_G;
            CHAR_T, CHAR_U: code = BASE_T;
            default:        code = BASE_MISSING;
        endcase
        return code;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

/* sv/alignment_site_statistics_top.sv */
// Alignment site statistics: per-sequence site counts and per-column variability totals.
// Each beat passes through the stage 1 register and then the output register.
// Throughput: one beat per cycle unless the output stalls; the per-sequence count memory does
// at most one read and one write each cycle, with same-entry forwarding between back-to-back
// beats. Reset clears control, column position, totals and tallies at once; the count memory
// is not cleared (the first column of each alignment starts every count from zero).
module alignment_site_statistics_top
    import ast_pkg::*;
#(
    parameter int MAX_SEQUENCES = 256,
    parameter int MAX_COLUMNS   = 65536
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // base_char[7:0], seq_num[15:8]
    input  logic         s_axis_tlast,   // column_end
    input  logic         s_axis_tuser,   // start_alignment
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // valid_count, missing_count, variable_total,
                                         // informative_total, column_position,
                                         // partition_position, zero pad
    output logic         m_axis_tlast,   // column_done
    output logic [2:0]   m_axis_tuser    // column_variable, column_informative, partition_marker
);

    localparam int AW = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
    localparam int IW = ((AW > 8) ? AW : 8) + 1;
    localparam logic [IW-1:0] SEQ_LIMIT = IW'(MAX_SEQUENCES);
    localparam longint COL_LIM_L = ((MAX_COLUMNS - 1) < 131071) ? (MAX_COLUMNS - 1) : 131071;
    localparam logic [CNT_W-1:0] COL_LIM = CNT_W'(COL_LIM_L);

    // count memory
    site_count_t mem [MAX_SEQUENCES];

    // control state
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   var_tot_reg, var_tot_next;
    logic [CNT_W-1:0]   inf_tot_reg, inf_tot_next;
    logic [TALLY_W-1:0] tally_reg [4];
    logic [TALLY_W-1:0] tally_next [4];
    logic               s1_valid_reg;
    logic               out_valid_reg;

    // stage 1 payload
    logic [AW-1:0]      s1_addr_reg;
    logic               s1_in_range_reg;
    logic               s1_zero_reg;
    logic               s1_missing_reg;
    logic               s1_end_reg;
    logic               s1_var_reg;
    logic               s1_inf_reg;
    logic [CNT_W-1:0]   s1_var_tot_reg;
    logic [CNT_W-1:0]   s1_inf_tot_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic               s1_mark_reg;
    logic [CNT_W-1:0]   s1_ppos_reg;
    site_count_t        rd_data_reg;
    logic               fwd_hit_reg;
    site_count_t        fwd_data_reg;

    // output register payload
    site_count_t        out_cnt_reg;
    logic               out_end_reg;
    logic               out_var_reg;
    logic               out_inf_reg;
    logic [CNT_W-1:0]   out_var_tot_reg;
    logic [CNT_W-1:0]   out_inf_tot_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_mark_reg;
    logic [CNT_W-1:0]   out_ppos_reg;

    logic               in_fire;
    logic               s1_move;
    logic [7:0]         in_char;
    logic [7:0]         in_seq;
    logic [IW-1:0]      seq_ext;
    logic [AW-1:0]      in_addr;
    logic               in_range;
    base_code_t         in_code;
    logic [CNT_W-1:0]   col_cur;
    logic [CNT_W-1:0]   var_tot_cur;
    logic [CNT_W-1:0]   inf_tot_cur;
    logic [TALLY_W-1:0] tally_upd [4];
    logic [2:0]         seen;
    logic [2:0]         rep;
    logic               col_var;
    logic               col_inf;
    logic               in_mark;
    logic [CNT_W:0]     ppos_sum;
    logic [CNT_W-1:0]   ppos;
    logic [POS_W-1:0]   pos_sat;
    site_count_t        s1_base;
    site_count_t        s1_new;

    assign in_char  = s_axis_tdata[7:0];
    assign in_seq   = s_axis_tdata[15:8];
    assign seq_ext  = IW'(in_seq);
    assign in_addr  = seq_ext[AW-1:0];
    assign in_range = seq_ext < SEQ_LIMIT;
    assign in_code  = base_code(in_char);

    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        col_cur     = s_axis_tuser ? '0 : col_reg;
        var_tot_cur = s_axis_tuser ? '0 : var_tot_reg;
        inf_tot_cur = s_axis_tuser ? '0 : inf_tot_reg;
        seen        = '0;
        rep         = '0;
        for (int k = 0; k < 4; k++)
        begin
            tally_upd[k] = s_axis_tuser ? '0 : tally_reg[k];
        end
        case (in_code)
            BASE_A:  tally_upd[0] = (tally_upd[0] == TALLY_MAX) ? TALLY_MAX : tally_upd[0] + 1'b1;
            BASE_C:  tally_upd[1] = (tally_upd[1] == TALLY_MAX) ? TALLY_MAX : tally_upd[1] + 1'b1;
            BASE_G:  tally_upd[2] = (tally_upd[2] == TALLY_MAX) ? TALLY_MAX : tally_upd[2] + 1'b1;
            BASE_T:  tally_upd[3] = (tally_upd[3] == TALLY_MAX) ? TALLY_MAX : tally_upd[3] + 1'b1;
            default: ;
        endcase
        for (int k = 0; k < 4; k++)
        begin
            seen = seen + 3'(tally_upd[k] != '0);
            rep  = rep + 3'(tally_upd[k] >= TALLY_W'(2));
        end
        col_var = s_axis_tlast && (seen > 3'd1);
        col_inf = s_axis_tlast && (rep >= 3'd2);

        var_tot_next = col_var ? sat_inc(var_tot_cur) : var_tot_cur;
        inf_tot_next = col_inf ? sat_inc(inf_tot_cur) : inf_tot_cur;
        col_next     = (s_axis_tlast && col_cur < COL_LIM) ? col_cur + 1'b1 : col_cur;
        for (int k = 0; k < 4; k++)
        begin
            tally_next[k] = s_axis_tlast ? '0 : tally_upd[k];
        end

        pos_sat  = (col_cur > CNT_W'(POS_MAX)) ? POS_MAX : col_cur[POS_W-1:0];
        in_mark  = (in_seq == 8'd0) && (in_char == CHAR_BANG);
        ppos_sum = {1'b0, col_cur} + 1'b1;
        ppos     = in_mark ? ((col_cur == CNT_MAX) ? CNT_MAX : ppos_sum[CNT_W-1:0]) : '0;
    end

    always_comb
    begin
        s1_base = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        if (s1_zero_reg)
        begin
            s1_base = '0;
        end
        s1_new = s1_base;
        if (s1_missing_reg)
        begin
            s1_new.missing = sat_inc(s1_base.missing);
        end
        else
        begin
            s1_new.valid = sat_inc(s1_base.valid);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            var_tot_reg   <= '0;
            inf_tot_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                tally_reg[k] <= '0;
            end
        end
        else
        begin
            if (in_fire)
            begin
                col_reg     <= col_next;
                var_tot_reg <= var_tot_next;
                inf_tot_reg <= inf_tot_next;
                for (int k = 0; k < 4; k++)
                begin
                    tally_reg[k] <= tally_next[k];
                end
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg     <= mem[in_addr];
            fwd_hit_reg     <= s1_move && s1_in_range_reg && (s1_addr_reg == in_addr);
            fwd_data_reg    <= s1_new;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_zero_reg     <= (col_cur == '0);
            s1_missing_reg  <= (in_code == BASE_MISSING);
            s1_end_reg      <= s_axis_tlast;
            s1_var_reg      <= col_var;
            s1_inf_reg      <= col_inf;
            s1_var_tot_reg  <= var_tot_next;
            s1_inf_tot_reg  <= inf_tot_next;
            s1_pos_reg      <= pos_sat;
            s1_mark_reg     <= in_mark;
            s1_ppos_reg     <= ppos;
        end
        if (s1_move && s1_in_range_reg)
        begin
            mem[s1_addr_reg] <= s1_new;
        end
        if (s1_move)
        begin
            out_cnt_reg     <= s1_in_range_reg ? s1_new : '0;
            out_end_reg     <= s1_end_reg;
            out_var_reg     <= s1_var_reg;
            out_inf_reg     <= s1_inf_reg;
            out_var_tot_reg <= s1_var_tot_reg;
            out_inf_tot_reg <= s1_inf_tot_reg;
            out_pos_reg     <= s1_pos_reg;
            out_mark_reg    <= s1_mark_reg;
            out_ppos_reg    <= s1_ppos_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_ppos_reg, out_pos_reg, out_inf_tot_reg,
                            out_var_tot_reg, out_cnt_reg.missing, out_cnt_reg.valid};
    assign m_axis_tlast  = out_end_reg;
    assign m_axis_tuser  = {out_mark_reg, out_inf_reg, out_var_reg};

endmodule

/* sv/ast_checker.sv */
// Port-level checker for the alignment site statistics block, bound to the top level.
module ast_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic [2:0]   m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_flags_need_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[1:0] == 2'b00)
        else $error("column flags set on a beat that closes no column");

    a_inf_is_var: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("informative column not flagged variable");

    a_marker_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[2] ? (m_axis_tdata[100:84] != 17'd0)
                                           : (m_axis_tdata[100:84] == 17'd0)))
        else $error("partition position disagrees with marker");

endmodule

bind alignment_site_statistics_top ast_checker u_ast_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/alignment_site_statistics_checker.sv */
// Checker: watches both stream channels, predicts each result beat and compares it.
`timescale 1ns / 100ps
module alignment_site_statistics_checker
    import ast_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic [2:0]   m_axis_tuser,
    output int unsigned  mismatches,
    output int unsigned  outstanding
);

    localparam int SEQ_DEPTH   = 256;
    localparam int LAST_COLUMN = 65535;

    typedef struct packed {
        logic [CNT_W-1:0] valid_count;
        logic [CNT_W-1:0] missing_count;
        logic [CNT_W-1:0] variable_total;
        logic [CNT_W-1:0] informative_total;
        logic [POS_W-1:0] column_position;
        logic [CNT_W-1:0] partition_position;
        logic             column_done;
        logic             column_variable;
        logic             column_informative;
        logic             partition_marker;
    } site_result_t;

    logic [CNT_W-1:0]   valid_store   [SEQ_DEPTH];
    logic [CNT_W-1:0]   missing_store [SEQ_DEPTH];
    logic [TALLY_W-1:0] base_tally    [4];
    logic [CNT_W-1:0]   column_count;
    logic [CNT_W-1:0]   variable_count;
    logic [CNT_W-1:0]   informative_count;
    site_result_t       expected_sites [$];
    int unsigned        fail_total;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            fail_total++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [7:0]       ch;
        logic [7:0]       idx;
        logic [7:0]       up;
        base_code_t       code;
        logic [CNT_W-1:0] vs;
        logic [CNT_W-1:0] ms;
        int               seen;
        int               rep;
        site_result_t     res;
        site_result_t     want;
        site_result_t     got;
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                base_tally[k] = '0;
            end
            column_count      = '0;
            variable_count    = '0;
            informative_count = '0;
            expected_sites.delete();
            fail_total  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                ch  = s_axis_tdata[7:0];
                idx = s_axis_tdata[15:8];
                res = '0;
                if (s_axis_tuser)
                begin
                    column_count      = '0;
                    variable_count    = '0;
                    informative_count = '0;
                    for (int k = 0; k < 4; k++)
                    begin
                        base_tally[k] = '0;
                    end
                end
                up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
                case (up)
                    "A":      code = BASE_A;
                    "C":      code = BASE_C;
                    "G":      code = BASE_G;
                    "T", "U": code = BASE_T;
                    default:  code = BASE_MISSING;
                endcase
                vs = (column_count != 0) ? valid_store[idx] : '0;
                ms = (column_count != 0) ? missing_store[idx] : '0;
                if (code == BASE_MISSING)
                begin
                    ms = (ms == '1) ? ms : ms + 1'b1;
                end
                else
                begin
                    vs = (vs == '1) ? vs : vs + 1'b1;
                    if (base_tally[code - 1] != '1)
                    begin
                        base_tally[code - 1] = base_tally[code - 1] + 1'b1;
                    end
                end
                valid_store[idx]   = vs;
                missing_store[idx] = ms;
                res.valid_count     = vs;
                res.missing_count   = ms;
                res.column_position = column_count[POS_W-1:0];
                if (idx == 8'd0 && ch == "!")
                begin
                    res.partition_marker   = 1'b1;
                    res.partition_position = column_count + 1'b1;
                end
                if (s_axis_tlast)
                begin
                    seen = 0;
                    rep  = 0;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (base_tally[k] > 0)
                        begin
                            seen++;
                        end
                        if (base_tally[k] >= 2)
                        begin
                            rep++;
                        end
                        base_tally[k] = '0;
                    end
                    res.column_done        = 1'b1;
                    res.column_variable    = (seen > 1);
                    res.column_informative = (rep >= 2);
                    if (res.column_variable && variable_count != '1)
                    begin
                        variable_count = variable_count + 1'b1;
                    end
                    if (res.column_informative && informative_count != '1)
                    begin
                        informative_count = informative_count + 1'b1;
                    end
                    if (column_count < LAST_COLUMN)
                    begin
                        column_count = column_count + 1'b1;
                    end
                end
                res.variable_total    = variable_count;
                res.informative_total = informative_count;
                expected_sites.insert(expected_sites.size(), res);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sites.size() == 0)
                begin
                    fail_total++;
                    $error("result beat with no expected result waiting");
                end
                else
                begin
                    want = expected_sites.pop_front();
                    got.valid_count        = m_axis_tdata[16:0];
                    got.missing_count      = m_axis_tdata[33:17];
                    got.variable_total     = m_axis_tdata[50:34];
                    got.informative_total  = m_axis_tdata[67:51];
                    got.column_position    = m_axis_tdata[83:68];
                    got.partition_position = m_axis_tdata[100:84];
                    got.column_done        = m_axis_tlast;
                    got.column_variable    = m_axis_tuser[0];
                    got.column_informative = m_axis_tuser[1];
                    got.partition_marker   = m_axis_tuser[2];
                    check_field("valid site count", 32'(want.valid_count),
                                32'(got.valid_count));
                    check_field("missing site count", 32'(want.missing_count),
                                32'(got.missing_count));
                    check_field("variable_total", 32'(want.variable_total),
                                32'(got.variable_total));
                    check_field("informative_total", 32'(want.informative_total),
                                32'(got.informative_total));
                    check_field("column_position", 32'(want.column_position),
                                32'(got.column_position));
                    check_field("partition_position", 32'(want.partition_position),
                                32'(got.partition_position));
                    check_field("column_done", 32'(want.column_done),
                                32'(got.column_done));
                    check_field("column_variable", 32'(want.column_variable),
                                32'(got.column_variable));
                    check_field("column_informative", 32'(want.column_informative),
                                32'(got.column_informative));
                    check_field("partition_marker", 32'(want.partition_marker),
                                32'(got.partition_marker));
                end
            end
            mismatches  <= fail_total;
            outstanding <= expected_sites.size();
        end
    end

endmodule

/* tb/tb_alignment_site_statistics_top.sv */
// Testbench top: drives alignment character beats into the block and gives the verdict.
`timescale 1ns / 100ps
module tb_alignment_site_statistics_top;
    import ast_pkg::*;

    localparam int RANDOM_BEATS   = 1050;
    localparam int DIRECTED_BEATS = 23;
    localparam int BACKLOG_AT     = 600;
    localparam int BACKLOG_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic [2:0]   m_axis_tuser;
    int unsigned  mismatches;
    int unsigned  outstanding;

    int           beats_sent;
    int           idle_level;
    int           stim_column;
    bit           seen_index [256];
    bit           backlog_done;
    int           cycles;

    alignment_site_statistics_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    alignment_site_statistics_checker site_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_len(input int level);
        int r;
        int busy;
        if (level == 0)
        begin
            return 0;
        end
        busy = (level == 1) ? 80 : 55;
        r = $urandom_range(0, 99);
        if (r < busy)
        begin
            return 0;
        end
        if (r < 96)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_char(input int bang_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < bang_pct)
        begin
            return "!";
        end
        if (r < 75)
        begin
            case ($urandom_range(0, 9))
                0:       return "A";
                1:       return "C";
                2:       return "G";
                3:       return "T";
                4:       return "U";
                5:       return "a";
                6:       return "c";
                7:       return "g";
                8:       return "t";
                default: return "u";
            endcase
        end
        if (r < 90)
        begin
            case ($urandom_range(0, 5))
                0:       return "N";
                1:       return "n";
                2:       return "-";
                3:       return "?";
                4:       return ".";
                default: return "X";
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic [7:0] idx,
                             input logic col_end, input logic new_aln);
        int   gap;
        logic start_eff;
        start_eff = new_aln;
        if (!start_eff && stim_column != 0 && !seen_index[idx])
        begin
            start_eff = 1'b1;
        end
        if (start_eff)
        begin
            stim_column = 0;
        end
        seen_index[idx] = 1'b1;
        if (col_end && stim_column < 65535)
        begin
            stim_column++;
        end
        gap = idle_len(idle_level);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, ch};
        s_axis_tlast  <= col_end;
        s_axis_tuser  <= start_eff;
        do @(posedge clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    initial
    begin
        int hold;
        m_axis_tready <= 1'b0;
        backlog_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!backlog_done && beats_sent >= BACKLOG_AT)
            begin
                backlog_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(negedge clk);
            end
            else
            begin
                hold = idle_len(idle_level);
                if (hold == 0)
                begin
                    m_axis_tready <= 1'b1;
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (hold - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int         nseq;
        int         ncol;
        int         first_idx;
        int         nnoise;
        logic [7:0] consensus;
        logic [7:0] ch;
        beats_sent    = 0;
        stim_column   = 0;
        idle_level    = 1;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_beat("!",   8'd0,   1'b0, 1'b1);
        send_beat("A",   8'd1,   1'b0, 1'b0);
        send_beat("c",   8'd2,   1'b0, 1'b0);
        send_beat("g",   8'd3,   1'b0, 1'b0);
        send_beat("T",   8'd4,   1'b0, 1'b0);
        send_beat("u",   8'd5,   1'b0, 1'b0);
        send_beat("N",   8'd6,   1'b0, 1'b0);
        send_beat(8'hFF, 8'd7,   1'b0, 1'b0);
        send_beat(8'h00, 8'd255, 1'b1, 1'b0);
        send_beat("a",   8'd0,   1'b0, 1'b0);
        send_beat("A",   8'd1,   1'b0, 1'b0);
        send_beat("A",   8'd2,   1'b0, 1'b0);
        send_beat("z",   8'd255, 1'b1, 1'b0);
        send_beat("!",   8'd0,   1'b0, 1'b0);
        send_beat("G",   8'd1,   1'b0, 1'b0);
        send_beat("G",   8'd2,   1'b0, 1'b0);
        send_beat("t",   8'd3,   1'b0, 1'b0);
        send_beat("T",   8'd4,   1'b1, 1'b0);
        send_beat("C",   8'd0,   1'b0, 1'b0);
        send_beat("C",   8'd1,   1'b0, 1'b1);
        send_beat("A",   8'd2,   1'b1, 1'b0);
        send_beat("g",   8'd0,   1'b0, 1'b0);
        send_beat("U",   8'd5,   1'b1, 1'b0);

        while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS)
        begin
            idle_level = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < 85)
            begin
                nseq      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(3, 12);
                ncol      = $urandom_range(1, 8);
                first_idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 0;
                for (int c = 0; c < ncol; c++)
                begin
                    consensus = $urandom_range(0, 1) ? pick_char(0) : 8'h00;
                    for (int s = 0; s < nseq; s++)
                    begin
                        if (consensus != 8'h00 && $urandom_range(0, 4) != 0)
                        begin
                            ch = consensus;
                        end
                        else
                        begin
                            ch = pick_char((s == 0) ? 15 : 2);
                        end
                        send_beat(ch, 8'(first_idx + s), s == nseq - 1, c == 0 && s == 0);
                    end
                end
            end
            else
            begin
                nnoise = $urandom_range(5, 30);
                for (int n = 0; n < nnoise; n++)
                begin
                    ch = $urandom_range(0, 1) ? pick_char(10) : 8'($urandom_range(0, 255));
                    send_beat(ch, 8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                              $urandom_range(0, 9) == 0);
                end
            end
        end

        idle_level = 1;
        send_beat("A", 8'd0, 1'b0, 1'b1);
        for (int k = 0; k < 512; k++)
        begin
            send_beat("G", 8'(k), 1'b0, 1'b0);
        end
        send_beat("a", 8'd1, 1'b1, 1'b0);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/ast_pkg.sv
sv/alignment_site_statistics_top.sv
sv/ast_checker.sv
tb/alignment_site_statistics_checker.sv
tb/tb_alignment_site_statistics_top.sv
